// File: design/ptc_pkg.sv
package ptc_pkg;

   localparam int RawWidth  = 20;
   localparam int WordWidth = 32;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 64;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TEMPERATURE_CAL = 2'd0,
      CSR_PRESSURE_CAL_LOW = 2'd1,
      CSR_PRESSURE_CAL_HIGH = 2'd2,
      CSR_PRESSURE_CAL_LAST = 2'd3
   } csr_index_type;

   // All calibration words, already extended to 32-bit patterns.
   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
   } cal_type;

   // Word that travels alongside the pressure datapath.
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
   } side_type;

   // Arithmetic right shift of a 32-bit two's complement pattern.
   function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

endpackage

// File: design/ptc_temp.sv
module ptc_temp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ptc_pkg::cal_type     cal,
   input  logic                 in_valid,
   input  logic [19:0]          raw_t,
   input  logic [19:0]          raw_p,
   output logic                 out_valid,
   output ptc_pkg::side_type    out_side,
   output logic [31:0]          out_v1,
   output logic [19:0]          out_raw_p
);

   logic [4:0]  valid_ff;
   logic [19:0] rawp_ff [0:4];
   logic [31:0] a_ff, b_ff, m1_ff, bb_ff, v1t_ff, m2_ff, fine4_ff;
   logic [31:0] temp_ff, fine_ff, pv1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rawp_ff[0] <= raw_p;
         for (int i = 1; i < 5; i++) rawp_ff[i] <= rawp_ff[i-1];
         a_ff     <= {15'd0, raw_t[19:3]} - {cal.t1[30:0], 1'b0};
         b_ff     <= {16'd0, raw_t[19:4]} - cal.t1;
         m1_ff    <= a_ff * cal.t2;
         bb_ff    <= b_ff * b_ff;
         v1t_ff   <= ptc_pkg::asr32(m1_ff, 11);
         m2_ff    <= ptc_pkg::asr32(bb_ff, 12) * cal.t3;
         fine4_ff <= v1t_ff + ptc_pkg::asr32(m2_ff, 14);
         temp_ff  <= ptc_pkg::asr32({fine4_ff[29:0], 2'b00} + fine4_ff + 32'd128, 8);
         fine_ff  <= fine4_ff;
         pv1_ff   <= ptc_pkg::asr32(fine4_ff, 1) - 32'd64000;
      end
   end

   assign out_valid     = valid_ff[4];
   assign out_side.temp = temp_ff;
   assign out_side.fine = fine_ff;
   assign out_v1        = pv1_ff;
   assign out_raw_p     = rawp_ff[4];

endmodule

// File: design/ptc_press.sv
module ptc_press (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ptc_pkg::cal_type     cal,
   input  logic                 in_valid,
   input  ptc_pkg::side_type    in_side,
   input  logic [31:0]          in_v1,
   input  logic [19:0]          in_raw_p,
   output logic                 out_valid,
   output ptc_pkg::side_type    out_side,
   output logic [31:0]          dividend,
   output logic [31:0]          divisor,
   output logic                 doubled,
   output logic                 invalid
);

   logic [5:0]        valid_ff;
   ptc_pkg::side_type side_ff [0:5];
   logic [19:0]       rawp_ff [0:3];
   logic [31:0] sq_ff, mp5_ff, mp2_ff, v2a_ff, mp3_ff, mp5b_ff, mp2b_ff;
   logic [31:0] v2_ff, x_ff, mp1_ff, pnum_ff, div_ff, pm_ff;
   logic [31:0] dividend_ff, divisor_ff;
   logic        doubled_ff, invalid_ff;
   logic [31:0] q;

   assign q = ptc_pkg::asr32(in_v1, 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < 6; i++) side_ff[i] <= side_ff[i-1];
         rawp_ff[0] <= in_raw_p;
         for (int i = 1; i < 4; i++) rawp_ff[i] <= rawp_ff[i-1];
         sq_ff   <= q * q;
         mp5_ff  <= in_v1 * cal.p5;
         mp2_ff  <= cal.p2 * in_v1;
         v2a_ff  <= ptc_pkg::asr32(sq_ff, 11) * cal.p6;
         mp3_ff  <= cal.p3 * ptc_pkg::asr32(sq_ff, 13);
         mp5b_ff <= mp5_ff;
         mp2b_ff <= mp2_ff;
         v2_ff   <= ptc_pkg::asr32(v2a_ff + {mp5b_ff[30:0], 1'b0}, 2)
                    + {cal.p4[15:0], 16'd0};
         x_ff    <= ptc_pkg::asr32(ptc_pkg::asr32(mp3_ff, 3)
                    + ptc_pkg::asr32(mp2b_ff, 1), 18);
         mp1_ff  <= (32'd32768 + x_ff) * cal.p1;
         pnum_ff <= (32'd1048576 - {12'd0, rawp_ff[2]}) - ptc_pkg::asr32(v2_ff, 12);
         div_ff  <= ptc_pkg::asr32(mp1_ff, 15);
         pm_ff   <= pnum_ff * 32'd3125;
         invalid_ff  <= (div_ff == 32'd0);
         divisor_ff  <= div_ff;
         doubled_ff  <= pm_ff[31];
         dividend_ff <= pm_ff[31] ? pm_ff : {pm_ff[30:0], 1'b0};
      end
   end

   assign out_valid = valid_ff[5];
   assign out_side  = side_ff[5];
   assign dividend  = dividend_ff;
   assign divisor   = divisor_ff;
   assign doubled   = doubled_ff;
   assign invalid   = invalid_ff;

endmodule

// File: design/ptc_div.sv
module ptc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  ptc_pkg::side_type    in_side,
   input  logic [31:0]          dividend,
   input  logic [31:0]          divisor,
   input  logic                 in_doubled,
   input  logic                 in_invalid,
   output logic                 out_valid,
   output ptc_pkg::side_type    out_side,
   output logic [31:0]          quotient,
   output logic                 out_doubled,
   output logic                 out_invalid
);

   localparam int Steps = ptc_pkg::WordWidth;

   // One quotient bit per stage; the dividend shifts out at the top of n_ff
   // while quotient bits shift in at the bottom.
   logic              valid_ff   [0:Steps-1];
   logic [31:0]       rem_ff     [0:Steps-1];
   logic [31:0]       n_ff       [0:Steps-1];
   logic [31:0]       d_ff       [0:Steps-1];
   logic              dbl_ff     [0:Steps-1];
   logic              inv_ff     [0:Steps-1];
   ptc_pkg::side_type side_ff    [0:Steps-1];

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [31:0]       rem_prev, n_prev, d_prev;
      logic              v_prev, dbl_prev, inv_prev;
      ptc_pkg::side_type side_prev;
      logic [32:0]       trial;
      logic [32:0]       diff;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign n_prev    = dividend;
         assign d_prev    = divisor;
         assign v_prev    = in_valid;
         assign dbl_prev  = in_doubled;
         assign inv_prev  = in_invalid;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign n_prev    = n_ff[s-1];
         assign d_prev    = d_ff[s-1];
         assign v_prev    = valid_ff[s-1];
         assign dbl_prev  = dbl_ff[s-1];
         assign inv_prev  = inv_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign trial = {rem_prev, n_prev[31]};
      assign diff  = trial - {1'b0, d_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!diff[32]) begin
               rem_ff[s] <= diff[31:0];
            end else begin
               rem_ff[s] <= trial[31:0];
            end
            n_ff[s]    <= {n_prev[30:0], ~diff[32]};
            d_ff[s]    <= d_prev;
            dbl_ff[s]  <= dbl_prev;
            inv_ff[s]  <= inv_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid   = valid_ff[Steps-1];
   assign out_side    = side_ff[Steps-1];
   assign quotient    = n_ff[Steps-1];
   assign out_doubled = dbl_ff[Steps-1];
   assign out_invalid = inv_ff[Steps-1];

endmodule

// File: design/ptc_post.sv
module ptc_post (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ptc_pkg::cal_type     cal,
   input  logic                 in_valid,
   input  ptc_pkg::side_type    in_side,
   input  logic [31:0]          quotient,
   input  logic                 doubled,
   input  logic                 invalid,
   output logic                 out_valid,
   output ptc_pkg::side_type    out_side,
   output logic [31:0]          pressure,
   output logic                 out_invalid
);

   logic [2:0]        valid_ff;
   ptc_pkg::side_type side_ff [0:2];
   logic              inv_ff  [0:2];
   logic [31:0]       p_ff    [0:1];
   logic [31:0]       sqp_ff, m8_ff, m8b_ff, m9_ff, press_ff;
   logic [31:0]       pp;

   assign pp = doubled ? {quotient[30:0], 1'b0} : quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         inv_ff[0]  <= invalid;
         inv_ff[1]  <= inv_ff[0];
         inv_ff[2]  <= inv_ff[1];
         p_ff[0]    <= pp;
         p_ff[1]    <= p_ff[0];
         sqp_ff     <= {3'd0, pp[31:3]} * {3'd0, pp[31:3]};
         m8_ff      <= {2'd0, pp[31:2]} * cal.p8;
         m9_ff      <= cal.p9 * {13'd0, sqp_ff[31:13]};
         m8b_ff     <= m8_ff;
         if (inv_ff[1]) begin
            press_ff <= '0;
         end else begin
            press_ff <= p_ff[1] + ptc_pkg::asr32(ptc_pkg::asr32(m9_ff, 12)
                        + ptc_pkg::asr32(m8b_ff, 13) + cal.p7, 4);
         end
      end
   end

   assign out_valid   = valid_ff[2];
   assign out_side    = side_ff[2];
   assign pressure    = press_ff;
   assign out_invalid = inv_ff[2];

endmodule

// File: design/pressure_temperature_compensation.sv
// Barometric sensor compensation, 32-bit integer form. Each request word carries one
// pair of raw 20-bit readings; each response word carries the temperature in hundredths
// of a degree, the fine temperature and the pressure in whole pascals, with a flag that
// marks a zero pressure divisor (pressure then reads 0). All arithmetic wraps at 32 bits.
// The datapath is a 46-stage pipeline: 5 stages for temperature, 6 for the pressure
// divisor and dividend, 32 for the bit-per-stage divider and 3 for the final correction.
// A new word is accepted every cycle while the output side keeps taking words.
// A stall at the output freezes the whole pipeline. Calibration must be written over
// the csr port only while the block is idle; the block itself does not enforce this.
// The four registers hold the twelve factory words and reset to zero.
module pressure_temperature_compensation (
   input  logic        clock,
   input  logic        reset,
   // Request: raw temperature [19:0], raw pressure reading [39:20].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // Response: temperature_centi [31:0], fine_temperature [63:32], pressure_pa [95:64].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,
   // Response flag: pressure_invalid [0].
   output logic [0:0]  rsp_tuser,
   // Calibration register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [47:0] tcal_ff;
   logic [63:0] pcal_low_ff;
   logic [63:0] pcal_high_ff;
   logic [15:0] pcal_last_ff;
   ptc_pkg::cal_type cal;
   logic en;

   // Registers accept a write in every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff      <= '0;
         pcal_low_ff  <= '0;
         pcal_high_ff <= '0;
         pcal_last_ff <= '0;
      end else if (csr_valid) begin
         unique case (ptc_pkg::csr_index_type'(csr_index))
            ptc_pkg::CSR_TEMPERATURE_CAL:   tcal_ff      <= csr_data[47:0];
            ptc_pkg::CSR_PRESSURE_CAL_LOW:  pcal_low_ff  <= csr_data;
            ptc_pkg::CSR_PRESSURE_CAL_HIGH: pcal_high_ff <= csr_data;
            ptc_pkg::CSR_PRESSURE_CAL_LAST: pcal_last_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Unpack the calibration words; T1 and P1 are unsigned, the rest signed.
   assign cal.t1 = {16'd0, tcal_ff[15:0]};
   assign cal.t2 = ptc_pkg::sext16(tcal_ff[31:16]);
   assign cal.t3 = ptc_pkg::sext16(tcal_ff[47:32]);
   assign cal.p1 = {16'd0, pcal_low_ff[15:0]};
   assign cal.p2 = ptc_pkg::sext16(pcal_low_ff[31:16]);
   assign cal.p3 = ptc_pkg::sext16(pcal_low_ff[47:32]);
   assign cal.p4 = ptc_pkg::sext16(pcal_low_ff[63:48]);
   assign cal.p5 = ptc_pkg::sext16(pcal_high_ff[15:0]);
   assign cal.p6 = ptc_pkg::sext16(pcal_high_ff[31:16]);
   assign cal.p7 = ptc_pkg::sext16(pcal_high_ff[47:32]);
   assign cal.p8 = ptc_pkg::sext16(pcal_high_ff[63:48]);
   assign cal.p9 = ptc_pkg::sext16(pcal_last_ff);

   // The pipeline advances unless a finished word is waiting at the output.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic              t_valid;
   ptc_pkg::side_type t_side;
   logic [31:0]       t_v1;
   logic [19:0]       t_raw_p;

   ptc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cal       (cal),
      .in_valid  (req_tvalid),
      .raw_t     (req_tdata[19:0]),
      .raw_p     (req_tdata[39:20]),
      .out_valid (t_valid),
      .out_side  (t_side),
      .out_v1    (t_v1),
      .out_raw_p (t_raw_p)
   );

   logic              p_valid;
   ptc_pkg::side_type p_side;
   logic [31:0]       p_dividend, p_divisor;
   logic              p_doubled, p_invalid;

   ptc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cal       (cal),
      .in_valid  (t_valid),
      .in_side   (t_side),
      .in_v1     (t_v1),
      .in_raw_p  (t_raw_p),
      .out_valid (p_valid),
      .out_side  (p_side),
      .dividend  (p_dividend),
      .divisor   (p_divisor),
      .doubled   (p_doubled),
      .invalid   (p_invalid)
   );

   logic              d_valid;
   ptc_pkg::side_type d_side;
   logic [31:0]       d_quotient;
   logic              d_doubled, d_invalid;

   ptc_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (p_valid),
      .in_side     (p_side),
      .dividend    (p_dividend),
      .divisor     (p_divisor),
      .in_doubled  (p_doubled),
      .in_invalid  (p_invalid),
      .out_valid   (d_valid),
      .out_side    (d_side),
      .quotient    (d_quotient),
      .out_doubled (d_doubled),
      .out_invalid (d_invalid)
   );

   ptc_pkg::side_type o_side;
   logic [31:0]       o_pressure;
   logic              o_invalid;

   ptc_post u_post (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .cal         (cal),
      .in_valid    (d_valid),
      .in_side     (d_side),
      .quotient    (d_quotient),
      .doubled     (d_doubled),
      .invalid     (d_invalid),
      .out_valid   (rsp_tvalid),
      .out_side    (o_side),
      .pressure    (o_pressure),
      .out_invalid (o_invalid)
   );

   assign rsp_tdata = {o_pressure, o_side.fine, o_side.temp};
   assign rsp_tuser = o_invalid;

   // A flagged word always reports zero pressure.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[95:64] == 32'd0)
      else $error("invalid pressure word carries nonzero pressure");

   // The request side is held off exactly while a result waits.
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow output stall");

   // Reset empties the pipeline.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

// File: dv/tb_pressure_temperature_compensation.sv
module tb_pressure_temperature_compensation;
   timeunit 1ns;
   timeprecision 1ps;

   // One compensated reading as it leaves the block.
   typedef struct {
      logic [31:0] temp_centi;
      logic [31:0] fine_temp;
      logic [31:0] pressure;
      logic        invalid;
   } reading_type;

   // Tracks the calibration in force and the readings still owed by the block.
   class compensation_scoreboard;
      logic [47:0] temp_cal;
      logic [63:0] pres_cal_lo;
      logic [63:0] pres_cal_hi;
      logic [15:0] pres_cal_p9;
      reading_type owed[$];
      int          mismatches;

      function new();
         temp_cal = '0;
         pres_cal_lo = '0;
         pres_cal_hi = '0;
         pres_cal_p9 = '0;
         mismatches = 0;
      endfunction

      function void write_cal(ptc_pkg::csr_index_type idx, logic [63:0] value);
         case (idx)
            ptc_pkg::CSR_TEMPERATURE_CAL: temp_cal = value[47:0];
            ptc_pkg::CSR_PRESSURE_CAL_LOW: pres_cal_lo = value;
            ptc_pkg::CSR_PRESSURE_CAL_HIGH: pres_cal_hi = value;
            ptc_pkg::CSR_PRESSURE_CAL_LAST: pres_cal_p9 = value[15:0];
         endcase
      endfunction

      static function logic [31:0] sra(logic [31:0] x, int n);
         return $signed(x) >>> n;
      endfunction

      static function logic [31:0] sx(logic [15:0] x);
         return {{16{x[15]}}, x};
      endfunction

      // Datasheet integer compensation, every step wrapping at 32 bits.
      function reading_type compensate(logic [19:0] raw_t, logic [19:0] raw_p);
         reading_type r;
         logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic [31:0] a, b, v1, v2, q, sq, fine, p;
         t1 = {16'h0, temp_cal[15:0]};
         t2 = sx(temp_cal[31:16]);
         t3 = sx(temp_cal[47:32]);
         p1 = {16'h0, pres_cal_lo[15:0]};
         p2 = sx(pres_cal_lo[31:16]);
         p3 = sx(pres_cal_lo[47:32]);
         p4 = sx(pres_cal_lo[63:48]);
         p5 = sx(pres_cal_hi[15:0]);
         p6 = sx(pres_cal_hi[31:16]);
         p7 = sx(pres_cal_hi[47:32]);
         p8 = sx(pres_cal_hi[63:48]);
         p9 = sx(pres_cal_p9);
         a = 32'(raw_t >> 3) - (t1 << 1);
         v1 = sra(a * t2, 11);
         b = 32'(raw_t >> 4) - t1;
         v2 = sra(sra(b * b, 12) * t3, 14);
         fine = v1 + v2;
         r.temp_centi = sra(fine * 32'd5 + 32'd128, 8);
         r.fine_temp = fine;
         v1 = sra(fine, 1) - 32'd64000;
         q = sra(v1, 2);
         sq = q * q;
         v2 = sra(sq, 11) * p6;
         v2 = v2 + ((v1 * p5) << 1);
         v2 = sra(v2, 2) + (p4 << 16);
         v1 = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * v1, 1), 18);
         v1 = sra((32'd32768 + v1) * p1, 15);
         if (v1 == 0) begin
            r.pressure = '0;
            r.invalid = 1'b1;
         end else begin
            p = ((32'd1048576 - 32'(raw_p)) - sra(v2, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / v1;
            else p = (p / v1) * 32'd2;
            a = ((p >> 3) * (p >> 3)) >> 13;
            v1 = sra(p9 * a, 12);
            v2 = sra((p >> 2) * p8, 13);
            r.pressure = p + sra(v1 + v2 + p7, 4);
            r.invalid = 1'b0;
         end
         return r;
      endfunction

      function void note_request(logic [39:0] word);
         owed.push_back(compensate(word[19:0], word[39:20]));
      endfunction

      function void check_response(logic [95:0] word, logic flag);
         reading_type want;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response word %h", word);
            return;
         end
         want = owed.pop_front();
         if (word[31:0] !== want.temp_centi || word[63:32] !== want.fine_temp ||
             word[95:64] !== want.pressure || flag !== want.invalid) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected t=%h f=%h p=%h inv=%b, got t=%h f=%h p=%h inv=%b",
                        want.temp_centi, want.fine_temp, want.pressure, want.invalid,
                        word[31:0], word[63:32], word[95:64], flag);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   pressure_temperature_compensation dut (.*);

   always #5 clock = ~clock;

   compensation_scoreboard board = new();

   // Percent chances of an idle sender cycle and of a stalled receiver cycle.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // While set, the receiver takes nothing so the pipeline fills and backs up.
   bit hold_receiver = 1'b0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;

   // Every accepted word in either direction goes to the scoreboard at the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser[0]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever hold_receiver is set.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_receiver && ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (idle_cycles > 5000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Writes one register, then leaves the channel idle.
   task automatic write_csr(ptc_pkg::csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_cal(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one word, with a random number of idle cycles ahead of it.
   task automatic send_pair(logic [19:0] raw_t, logic [19:0] raw_p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {raw_p, raw_t};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Typical factory calibration; temperature and pressure come out realistic.
   task automatic typical_cal();
      write_csr(ptc_pkg::CSR_TEMPERATURE_CAL, 64'({16'hFC18, 16'h6672, 16'h6E93}));
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_LOW, {16'h0AF9, 16'h2CB2, 16'hD6D0, 16'h8F43});
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_HIGH, {16'h3D70, 16'h3AF2, 16'hFFF9, 16'h008C});
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_LAST, 64'h1770);
   endtask

   task automatic random_cal();
      write_csr(ptc_pkg::CSR_TEMPERATURE_CAL, {$urandom, $urandom});
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_LOW, {$urandom, $urandom});
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_HIGH, {$urandom, $urandom});
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_LAST, {$urandom, $urandom});
   endtask

   // Mostly realistic raw readings, with some fully random ones.
   task automatic random_pairs(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            send_pair(20'($urandom), 20'($urandom));
         else
            send_pair(20'($urandom_range(600000, 380000)),
                      20'($urandom_range(500000, 250000)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With all calibration zero the divisor is zero, so every
      // word must come back flagged invalid.
      send_pair(20'h00000, 20'h00000);
      send_pair(20'hFFFFF, 20'hFFFFF);
      drain();
      typical_cal();
      send_pair(20'd519888, 20'd415148);
      send_pair(20'h00000, 20'hFFFFF);
      send_pair(20'hFFFFF, 20'h00000);
      send_pair(20'h55555, 20'hAAAAA);
      send_pair(20'hAAAAA, 20'h55555);
      drain();
      // Extreme calibration: all ones, then smallest and largest signed words.
      write_csr(ptc_pkg::CSR_TEMPERATURE_CAL, 64'hFFFF_FFFF_FFFF);
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_LOW, '1);
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_HIGH, '1);
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_LAST, 64'hFFFF);
      send_pair(20'h00000, 20'h00000);
      send_pair(20'hFFFFF, 20'hFFFFF);
      send_pair(20'h12345, 20'hEDCBA);
      drain();
      write_csr(ptc_pkg::CSR_TEMPERATURE_CAL, 64'h8000_7FFF_FFFF);
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_LOW, 64'h7FFF_8000_7FFF_FFFF);
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_HIGH, 64'h8000_7FFF_8000_7FFF);
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_LAST, 64'h8000);
      send_pair(20'h00000, 20'hFFFFF);
      send_pair(20'hFFFFF, 20'h00000);
      drain();
      // Pressure scale factor of zero forces the zero divisor case.
      typical_cal();
      write_csr(ptc_pkg::CSR_PRESSURE_CAL_LOW, {16'h0AF9, 16'h2CB2, 16'hD6D0, 16'h0000});
      send_pair(20'd519888, 20'd415148);
      send_pair(20'hFFFFF, 20'h00000);
      drain();

      // Random part: two phases per idling mix, the first four with typical calibration, the rest random.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         if (phase < 4) typical_cal();
         else random_cal();
         random_pairs(150);
         drain();
      end

      // Back-pressure: the receiver holds off long enough for the pipeline to fill
      // and stall the input, while the sender keeps offering words.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      typical_cal();
      fork
         begin
            hold_receiver = 1'b1;
            repeat (300) @(posedge clock);
            hold_receiver = 1'b0;
         end
         random_pairs(100);
      join
      drain();

      if (board.mismatches == 0 && board.owed.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
